@@ hdl/ptx_pkg.sv @@
`timescale 1ns / 1ps
package ptx_pkg;

  localparam int COORD_W    = 32;
  localparam int COEF_W     = 32;
  localparam int PARAM_W    = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int DATA_W     = 3 * COORD_W;

  localparam int DIFF_W     = COORD_W + 1;
  localparam int ROT1_W     = DIFF_W + 3;
  localparam int ROT2_W     = ROT1_W + 3;
  localparam int ROT3_W     = ROT2_W + 3;
  localparam int SP_W       = DIFF_W + COEF_W;
  localparam int SCALE_FRAC = 16;
  localparam int SCL_W      = SP_W - SCALE_FRAC;
  localparam int LIN_W      = SCL_W + 1;
  localparam int ROT_FRAC   = 30;
  localparam int ROT_SPLIT  = 20;

  localparam int ST_IN      = 0;
  localparam int ST_ROTX    = 1;
  localparam int ST_ROTY    = 4;
  localparam int ST_ROTZ    = 7;
  localparam int ST_OUT     = 10;
  localparam int PIPE_DEPTH = 11;

  typedef enum logic [1:0] {
    MODE_TRANSLATE = 2'd0,
    MODE_SCALE     = 2'd1,
    MODE_ROTATE    = 2'd2,
    MODE_PASS      = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE     = 3'd0,
    CFG_ORIGIN_X = 3'd1,
    CFG_ORIGIN_Y = 3'd2,
    CFG_ORIGIN_Z = 3'd3,
    CFG_AXIS_X   = 3'd4,
    CFG_AXIS_Y   = 3'd5,
    CFG_AXIS_Z   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic mul;
    logic rnd;
    logic sum;
  } step_en_t;

endpackage

@@ hdl/point_transform_3d_unit.sv @@
`timescale 1ns / 1ps
// Throughput: one item per cycle unless the output stalls; each of the 11
// pipeline registers holds one item and advances whenever the register after it
// is empty or moving.
// Reset (rst_ni low, asynchronous) clears all valid bits and the configuration
// registers to zero (mode translate); datapath registers are not reset.
module point_transform_3d_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ptx_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ptx_pkg::PARAM_W-1:0]       cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [ptx_pkg::DATA_W-1:0]        s_axis_tdata,   // in_x, in_y, in_z
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [ptx_pkg::DATA_W-1:0]        m_axis_tdata,   // out_x, out_y, out_z
  output logic                              m_axis_tuser    // clipped
);
  import ptx_pkg::*;

  localparam logic signed [SP_W-1:0] SCL_HALF =
    {{(SP_W - SCALE_FRAC){1'b0}}, 1'b1, {(SCALE_FRAC - 1){1'b0}}};

  function automatic logic signed [SCL_W-1:0] round_q16(input logic signed [SP_W-1:0] p);
    logic signed [SP_W-1:0] adj;
    adj = p + SCL_HALF - SP_W'(p[SP_W-1]);
    return SCL_W'(adj >>> SCALE_FRAC);
  endfunction

  mode_e                       mode_q;
  logic signed [COORD_W-1:0]   org_q [3];
  logic [PARAM_W-1:0]          prm_q [3];
  logic signed [COEF_W-1:0]    coef [3];
  logic signed [COEF_W-1:0]    sine [3];
  logic signed [COORD_W-1:0]   in_c [3];

  logic [PIPE_DEPTH-1:0]       vld_q;
  logic [PIPE_DEPTH:0]         rdy;
  logic [PIPE_DEPTH-1:0]       ld;

  logic signed [DIFF_W-1:0]    dif_q [3];
  logic signed [DIFF_W-1:0]    tr0_q [3];
  logic signed [SP_W-1:0]      sp_q [3];
  logic signed [DIFF_W-1:0]    tr1_q [3];
  logic signed [LIN_W-1:0]     lin_q [2:9][3];
  logic signed [DIFF_W-1:0]    dx_q [1:3];
  logic signed [ROT1_W-1:0]    y1_q [4:6];
  logic signed [ROT2_W-1:0]    z2_q [7:9];

  step_en_t                    en_x, en_y, en_z;
  logic signed [ROT1_W-1:0]    rx_u, rx_w;
  logic signed [ROT2_W-1:0]    ry_u, ry_w;
  logic signed [ROT3_W-1:0]    rz_u, rz_w;
  logic signed [ROT3_W-1:0]    rot_fin [3];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TRANSLATE;
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= '0;
        prm_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODE:     mode_q   <= mode_e'(cfg_data_i[1:0]);
        CFG_ORIGIN_X: org_q[0] <= cfg_data_i[COORD_W-1:0];
        CFG_ORIGIN_Y: org_q[1] <= cfg_data_i[COORD_W-1:0];
        CFG_ORIGIN_Z: org_q[2] <= cfg_data_i[COORD_W-1:0];
        CFG_AXIS_X:   prm_q[0] <= cfg_data_i;
        CFG_AXIS_Y:   prm_q[1] <= cfg_data_i;
        CFG_AXIS_Z:   prm_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      coef[i] = prm_q[i][COEF_W-1:0];
      sine[i] = prm_q[i][PARAM_W-1:COEF_W];
      in_c[i] = s_axis_tdata[i*COORD_W +: COORD_W];
    end
  end

  // pipeline flow control
  always_comb begin
    rdy[PIPE_DEPTH] = m_axis_tready;
    for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    ld[0] = s_axis_tvalid && rdy[0];
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      ld[k] = vld_q[k-1] && rdy[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[PIPE_DEPTH-1];

  // offsets from origin, translate sum, scale products
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (ld[ST_IN]) begin
        dif_q[i] <= DIFF_W'(in_c[i]) - DIFF_W'(org_q[i]);
        tr0_q[i] <= (mode_q == MODE_TRANSLATE) ? DIFF_W'(in_c[i]) + DIFF_W'(coef[i])
                                               : DIFF_W'(in_c[i]);
      end
      if (ld[ST_ROTX]) begin
        sp_q[i]  <= dif_q[i] * coef[i];
        tr1_q[i] <= tr0_q[i];
      end
      if (ld[ST_ROTX+1]) begin
        lin_q[2][i] <= (mode_q == MODE_SCALE)
                       ? LIN_W'(round_q16(sp_q[i])) + LIN_W'(org_q[i])
                       : LIN_W'(tr1_q[i]);
      end
    end
    for (int k = 3; k < ST_OUT; k++) begin
      if (ld[k]) lin_q[k] <= lin_q[k-1];
    end
  end

  // side values that wait for later rotation steps
  always_ff @(posedge clk_i) begin
    if (ld[ST_ROTX]) dx_q[1] <= dif_q[0];
    for (int k = 2; k <= 3; k++) begin
      if (ld[k]) dx_q[k] <= dx_q[k-1];
    end
    if (ld[ST_ROTY]) y1_q[4] <= rx_u;
    for (int k = 5; k <= 6; k++) begin
      if (ld[k]) y1_q[k] <= y1_q[k-1];
    end
    if (ld[ST_ROTZ]) z2_q[7] <= ry_u;
    for (int k = 8; k <= 9; k++) begin
      if (ld[k]) z2_q[k] <= z2_q[k-1];
    end
  end

  always_comb begin
    en_x = '{mul: ld[ST_ROTX], rnd: ld[ST_ROTX+1], sum: ld[ST_ROTX+2]};
    en_y = '{mul: ld[ST_ROTY], rnd: ld[ST_ROTY+1], sum: ld[ST_ROTY+2]};
    en_z = '{mul: ld[ST_ROTZ], rnd: ld[ST_ROTZ+1], sum: ld[ST_ROTZ+2]};
  end

  // about X: y1 = y c - z s, z1 = y s + z c
  ptx_rot_step #(.AW(DIFF_W)) u_rot_x (
    .clk_i (clk_i),
    .en_i  (en_x),
    .cos_i (coef[0]),
    .sin_i (sine[0]),
    .a_i   (dif_q[1]),
    .b_i   (dif_q[2]),
    .u_o   (rx_u),
    .w_o   (rx_w)
  );

  // about Y: z2 = z c - x s, x2 = z s + x c
  ptx_rot_step #(.AW(ROT1_W)) u_rot_y (
    .clk_i (clk_i),
    .en_i  (en_y),
    .cos_i (coef[1]),
    .sin_i (sine[1]),
    .a_i   (rx_w),
    .b_i   (ROT1_W'(dx_q[3])),
    .u_o   (ry_u),
    .w_o   (ry_w)
  );

  // about Z: x3 = x c - y s, y3 = x s + y c
  ptx_rot_step #(.AW(ROT2_W)) u_rot_z (
    .clk_i (clk_i),
    .en_i  (en_z),
    .cos_i (coef[2]),
    .sin_i (sine[2]),
    .a_i   (ry_w),
    .b_i   (ROT2_W'(y1_q[6])),
    .u_o   (rz_u),
    .w_o   (rz_w)
  );

  always_comb begin
    rot_fin[0] = rz_u;
    rot_fin[1] = rz_w;
    rot_fin[2] = ROT3_W'(z2_q[9]);
  end

  ptx_out_stage #(.COORD_WIDTH(COORD_WIDTH)) u_out (
    .clk_i  (clk_i),
    .en_i   (ld[ST_OUT]),
    .mode_i (mode_q),
    .org_i  (org_q),
    .rot_i  (rot_fin),
    .lin_i  (lin_q[9]),
    .data_o (m_axis_tdata),
    .clip_o (m_axis_tuser)
  );

endmodule

@@ hdl/ptx_rot_step.sv @@
`timescale 1ns / 1ps
module ptx_rot_step #(
  parameter int AW = 33
) (
  input  logic                                clk_i,
  input  ptx_pkg::step_en_t                   en_i,
  input  logic signed [ptx_pkg::COEF_W-1:0]   cos_i,
  input  logic signed [ptx_pkg::COEF_W-1:0]   sin_i,
  input  logic signed [AW-1:0]                a_i,
  input  logic signed [AW-1:0]                b_i,
  output logic signed [AW+2:0]                u_o,
  output logic signed [AW+2:0]                w_o
);
  import ptx_pkg::*;

  localparam int LO_W  = ROT_SPLIT;
  localparam int HI_W  = AW - LO_W;
  localparam int PLO_W = LO_W + 1 + COEF_W;
  localparam int PHI_W = HI_W + COEF_W;
  localparam int PW    = AW + COEF_W;
  localparam int RW    = AW + 2;
  localparam int OW    = AW + 3;
  localparam logic signed [PW-1:0] HALF =
    {{(PW - ROT_FRAC){1'b0}}, 1'b1, {(ROT_FRAC - 1){1'b0}}};

  logic signed [AW-1:0]     opa [4];
  logic signed [COEF_W-1:0] opk [4];
  logic signed [PLO_W-1:0]  plo_q [4];
  logic signed [PHI_W-1:0]  phi_q [4];
  logic signed [PW-1:0]     full [4];
  logic signed [PW-1:0]     adj [4];
  logic signed [RW-1:0]     rnd_q [4];
  logic signed [OW-1:0]     u_q;
  logic signed [OW-1:0]     w_q;

  // u = a*cos - b*sin, w = a*sin + b*cos
  always_comb begin
    opa[0] = a_i;  opk[0] = cos_i;
    opa[1] = b_i;  opk[1] = sin_i;
    opa[2] = a_i;  opk[2] = sin_i;
    opa[3] = b_i;  opk[3] = cos_i;
  end

  // split each product into a low unsigned and a high signed partial
  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      for (int i = 0; i < 4; i++) begin
        plo_q[i] <= $signed({1'b0, opa[i][LO_W-1:0]}) * opk[i];
        phi_q[i] <= $signed(opa[i][AW-1:LO_W]) * opk[i];
      end
    end
  end

  // round half away from zero
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      full[i] = (PW'(phi_q[i]) <<< LO_W) + PW'(plo_q[i]);
      adj[i]  = full[i] + HALF - PW'(full[i][PW-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.rnd) begin
      for (int i = 0; i < 4; i++) begin
        rnd_q[i] <= RW'(adj[i] >>> ROT_FRAC);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      u_q <= OW'(rnd_q[0]) - OW'(rnd_q[1]);
      w_q <= OW'(rnd_q[2]) + OW'(rnd_q[3]);
    end
  end

  assign u_o = u_q;
  assign w_o = w_q;

endmodule

@@ hdl/ptx_out_stage.sv @@
`timescale 1ns / 1ps
module ptx_out_stage #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  ptx_pkg::mode_e                       mode_i,
  input  logic signed [ptx_pkg::COORD_W-1:0]   org_i [3],
  input  logic signed [ptx_pkg::ROT3_W-1:0]    rot_i [3],
  input  logic signed [ptx_pkg::LIN_W-1:0]     lin_i [3],
  output logic [ptx_pkg::DATA_W-1:0]           data_o,
  output logic                                 clip_o
);
  import ptx_pkg::*;

  localparam logic signed [LIN_W-1:0] SAT_MAX =
    {{(LIN_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [LIN_W-1:0] SAT_MIN = ~SAT_MAX;

  logic signed [LIN_W-1:0] val [3];
  logic signed [LIN_W-1:0] sat [3];
  logic [2:0]              ovf;
  logic [DATA_W-1:0]       data_q;
  logic                    clip_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      val[i] = (mode_i == MODE_ROTATE) ? LIN_W'(rot_i[i]) + LIN_W'(org_i[i]) : lin_i[i];
      ovf[i] = !((&val[i][LIN_W-1:COORD_WIDTH-1]) || !(|val[i][LIN_W-1:COORD_WIDTH-1]));
      sat[i] = ovf[i] ? (val[i][LIN_W-1] ? SAT_MIN : SAT_MAX) : val[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        data_q[i*COORD_W +: COORD_W] <= sat[i][COORD_W-1:0];
      end
      clip_q <= |ovf;
    end
  end

  assign data_o = data_q;
  assign clip_o = clip_q;

endmodule

@@ hdl/ptx_checker.sv @@
`timescale 1ns / 1ps
module ptx_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [ptx_pkg::DATA_W-1:0]  m_axis_tdata,
  input logic                        m_axis_tuser
);
  import ptx_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_d;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cnt_d = cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output item changed while stalled");

  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tready || !m_axis_tvalid) |-> s_axis_tready)
    else $error("input stalled while output stage free");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cnt_q != '0))
    else $error("output item without accepted input");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CNT_W'(PIPE_DEPTH) && !m_axis_tready) |-> !s_axis_tready)
    else $error("full pipeline accepted an item while stalled");

endmodule

bind point_transform_3d_unit ptx_checker u_ptx_checker (.*);
